>>> sv/oaht_pkg.sv
`default_nettype none

package oaht_pkg;

  localparam int KEY_W      = 31;
  localparam int KEY_PAD_W  = 32;
  localparam int MODE_W     = 2;
  localparam int RES_W      = 3;
  localparam int SLOT_OUT_W = 4;
  localparam int SLOT_ST_W  = 2;
  localparam int WORD_W     = SLOT_ST_W + KEY_W;
  localparam int DIGIT_W    = 4;
  localparam int KEY_DIGITS = KEY_PAD_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(KEY_DIGITS);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

  localparam logic [RES_W-1:0] RES_INSERTED = 3'd0;
  localparam logic [RES_W-1:0] RES_FOUND    = 3'd1;
  localparam logic [RES_W-1:0] RES_DELETED  = 3'd2;
  localparam logic [RES_W-1:0] RES_MISSING  = 3'd3;
  localparam logic [RES_W-1:0] RES_FULL     = 3'd4;

  localparam logic [SLOT_ST_W-1:0] SLOT_EMPTY = 2'd0;
  localparam logic [SLOT_ST_W-1:0] SLOT_USED  = 2'd1;
  localparam logic [SLOT_ST_W-1:0] SLOT_TOMB  = 2'd2;

  localparam logic REG_PROBE_KIND = 1'b0;

  typedef struct packed {
    logic clr_we;
    logic load;
    logic mod_run;
    logic advance;
    logic commit;
    logic fail;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic take;
    logic stop;
    logic last;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

>>> sv/oaht_ctrl.sv
`default_nettype none

module oaht_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  oaht_pkg::stat_t  stat,
  output oaht_pkg::cmd_t   cmd
);
  import oaht_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.mod_run = 1'b1;
        if (stat.mod_done) state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (stat.take) begin
          cmd.commit = 1'b1;
          state_nxt  = S_OUT;
        end else if (stat.stop || stat.last) begin
          cmd.fail  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

endmodule

`default_nettype wire

>>> sv/oaht_dp.sv
`default_nettype none

module oaht_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                probe_kind,
  input  wire  [oaht_pkg::MODE_W-1:0]        in_mode,
  input  wire  [oaht_pkg::KEY_W-1:0]         in_key,
  input  oaht_pkg::cmd_t                     cmd,
  output oaht_pkg::stat_t                    stat,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [oaht_pkg::RES_W-1:0]         out_status,
  output logic [oaht_pkg::SLOT_OUT_W-1:0]    out_slot
);
  import oaht_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int AW1 = AW + 1;
  localparam logic [AW:0]   DEPTH_EXT = AW1'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_DEPTH - 1);

  logic [WORD_W-1:0]    mem [TABLE_DEPTH];
  logic [WORD_W-1:0]    rdata_r;

  logic [AW-1:0]        clr_addr_r;
  logic [MODE_W-1:0]    mode_r;
  logic [KEY_W-1:0]     key_r;
  logic [KEY_PAD_W-1:0] key_sr_r;
  logic [DIG_CNT_W-1:0] dig_cnt_r;
  logic [AW-1:0]        rem_r;
  logic [AW-1:0]        rem_nxt;
  logic [AW-1:0]        pos_r;
  logic [AW-1:0]        pos_nxt;
  logic [AW-1:0]        step_r;
  logic [AW-1:0]        step_nxt;
  logic [AW-1:0]        cnt_r;
  logic [RES_W-1:0]     res_status_r;
  logic [AW-1:0]        res_slot_r;
  logic                 out_valid_r;
  logic [RES_W-1:0]     out_status_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;

  logic [SLOT_ST_W-1:0] rd_st;
  logic [KEY_W-1:0]     rd_key;
  logic                 key_eq;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WORD_W-1:0]    wdata;
  logic [AW+SLOT_OUT_W-1:0] slot_ext;

  // remainder of the key by the table depth, one nibble per cycle
  always_comb begin
    logic [AW:0]   t;
    logic [AW-1:0] r;
    r = rem_r;
    for (int j = 0; j < DIGIT_W; j++) begin
      t = {r, key_sr_r[KEY_PAD_W-1-j]};
      if (t >= DEPTH_EXT) t = t - DEPTH_EXT;
      r = t[AW-1:0];
    end
    rem_nxt = r;
  end

  // next probe slot and step: pos + step mod depth, step grows by 2 for quadratic
  always_comb begin
    logic [AW:0] psum;
    logic [AW:0] ssum;
    psum = {1'b0, pos_r} + {1'b0, step_r};
    if (psum >= DEPTH_EXT) psum = psum - DEPTH_EXT;
    pos_nxt = psum[AW-1:0];
    ssum = {1'b0, step_r} + AW1'(2);
    if (ssum >= DEPTH_EXT) ssum = ssum - DEPTH_EXT;
    step_nxt = probe_kind ? ssum[AW-1:0] : step_r;
  end

  assign rd_st  = rdata_r[WORD_W-1 -: SLOT_ST_W];
  assign rd_key = rdata_r[KEY_W-1:0];
  assign key_eq = (rd_key == key_r);

  always_comb begin
    stat          = '0;
    stat.clr_last = (clr_addr_r == LAST_IDX);
    stat.mod_done = (dig_cnt_r == DIG_CNT_W'(KEY_DIGITS - 1));
    stat.last     = (cnt_r == LAST_IDX);
    stat.out_busy = out_valid_r && !out_tready;
    unique case (mode_r)
      MODE_INSERT: begin
        stat.take = (rd_st != SLOT_USED);
        stat.stop = 1'b0;
      end
      MODE_SEARCH, MODE_DELETE: begin
        stat.take = (rd_st == SLOT_USED) && key_eq;
        stat.stop = (rd_st == SLOT_EMPTY);
      end
      default: begin
        stat.take = 1'b0;
        stat.stop = 1'b1;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = {SLOT_USED, key_r};
    if (cmd.clr_we) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = {SLOT_EMPTY, {KEY_W{1'b0}}};
    end else if (cmd.commit && mode_r == MODE_INSERT) begin
      we = 1'b1;
    end else if (cmd.commit && mode_r == MODE_DELETE) begin
      we    = 1'b1;
      wdata = {SLOT_TOMB, rd_key};
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_we) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      key_r     <= in_key;
      key_sr_r  <= {1'b0, in_key};
      dig_cnt_r <= '0;
      rem_r     <= '0;
    end else if (cmd.mod_run) begin
      key_sr_r  <= key_sr_r << DIGIT_W;
      dig_cnt_r <= dig_cnt_r + DIG_CNT_W'(1);
      rem_r     <= rem_nxt;
      if (stat.mod_done) begin
        pos_r  <= rem_nxt;
        step_r <= AW'(1);
        cnt_r  <= '0;
      end
    end else if (cmd.advance) begin
      pos_r  <= pos_nxt;
      step_r <= step_nxt;
      cnt_r  <= cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_slot_r <= pos_r;
      unique case (mode_r)
        MODE_INSERT: res_status_r <= RES_INSERTED;
        MODE_SEARCH: res_status_r <= RES_FOUND;
        MODE_DELETE: res_status_r <= RES_DELETED;
        default:     res_status_r <= RES_MISSING;
      endcase
    end else if (cmd.fail) begin
      res_slot_r   <= '0;
      res_status_r <= (mode_r == MODE_INSERT) ? RES_FULL : RES_MISSING;
    end
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_slot_r   <= slot_ext[SLOT_OUT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule

`default_nettype wire

>>> sv/open_addressing_hash_table_top.sv
// Each input transaction makes P probes, P from 1 to TABLE_DEPTH, before its result.
// Key hashing feeds the key through the remainder unit one key nibble per cycle.
// Each probe is a slot-memory read, then a check and optional write.
// One item in flight: a new input is taken only once the last result is held in the output register.
// Reset: synchronous, active low; a clearing pass over all TABLE_DEPTH slots marks every slot empty,
// with in_tready low until it ends. probe_kind resets to linear.
`default_nettype none

module open_addressing_hash_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,    // [30:0] key
  input  wire  [1:0]  in_tuser,    // [1:0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,   // [3:0] slot_index
  output logic [2:0]  out_tuser,   // [2:0] status
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire  [oaht_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire  [oaht_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [oaht_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import oaht_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  probe_kind_r;
  logic  cfg_sel_kind;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [RES_W-1:0]      out_status;

  assign cfg_pready   = 1'b1;
  assign cfg_sel_kind = (cfg_paddr[CFG_ADDR_W-1:2] == REG_PROBE_KIND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_kind_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_kind) begin
      probe_kind_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = cfg_sel_kind ? {{(CFG_DATA_W-1){1'b0}}, probe_kind_r} : '0;

  oaht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  oaht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .probe_kind (probe_kind_r),
    .in_mode    (in_tuser),
    .in_key     (in_tdata[KEY_W-1:0]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_status),
    .out_slot   (out_slot)
  );

  assign out_tdata = {{(8-SLOT_OUT_W){1'b0}}, out_slot};
  assign out_tuser = out_status;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result overwrote a pending transaction");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_status <= RES_FULL))
    else $error("status code out of range");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_status == RES_MISSING || out_status == RES_FULL)) |-> (out_slot == '0))
    else $error("slot index nonzero on miss or full");

endmodule

`default_nettype wire
